// ===== design/lr3d_pkg.sv =====
package lr3d_pkg;

  // Weight is a percentage: full scale and its width are fixed.
  localparam int unsigned WEIGHT_W = 7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 7'd100;

  // Divider iteration counter indexes the bits of WEIGHT_FULL.
  localparam int unsigned DIV_CNT_W = $clog2(WEIGHT_W);
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_TOP = DIV_CNT_W'(WEIGHT_W - 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_t;

  // Dominant axis codes.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_DIV   = 2'd2,
    ST_WALK  = 2'd3
  } state_t;

endpackage

// ===== design/line_rasterizer_3d_unit.sv =====
// 3D Bresenham line walker. Each input beat carries two voxel endpoints;
// the unit emits one output beat per point of the line from the first
// endpoint to the second, in walk order, with the point's in-bounds flag
// against the size_x/size_y/size_z registers, the colour weight toward
// the first endpoint in percent (truncated, taken on the dominant axis),
// and a last mark on the second endpoint. The dominant axis is the one
// with the largest delta, ties going to x, then y, then z. After an input
// beat is taken the unit passes a setup state, then a radix-2 divider that
// forms 100 / span once per line (span = dominant-axis delta; skipped
// when span is zero), then walks one point per cycle into the output
// register, slowed only by out_stall. The unit returns to idle once the
// last point of a line has been loaded, and only in idle can the next
// input beat be taken. in_stall is high from the accepted input beat
// until the last point has been loaded into the output register; the
// next line may then be taken while that point still waits downstream.
// Per-point weights come from an incremental quotient/remainder update,
// so the divider runs once per line. Configuration writes are always
// taken (cfg_ready is tied high) and should only be issued while the
// unit is idle; writes to an index beyond size_z are dropped.
module line_rasterizer_3d_unit
  import lr3d_pkg::*;
#(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_start_z,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [COORD_BITS-1:0] in_end_z,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic [COORD_BITS-1:0] out_point_z,
  output logic                  out_inside_res,
  output logic [WEIGHT_W-1:0]   out_weight_pct,
  output logic                  out_last,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS:0]   cfg_data
);

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned SIZE_W = COORD_BITS + 1;
  localparam int unsigned ERR_W  = COORD_BITS + 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = {1'b1, {COORD_BITS{1'b0}}};
  localparam logic [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0] MONE = {CW{1'b1}};

  state_t state_r, state_nxt;

  // Volume size registers.
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

  // Captured endpoints.
  logic [CW-1:0] s_x_r, s_y_r, s_z_r, e_x_r, e_y_r, e_z_r;

  // Walker, in dominant / first minor / second minor role order.
  axis_t         maj_r;
  logic [CW-1:0] pm_r, p1_r, p2_r, end_m_r;
  logic          neg_m_r, neg1_r, neg2_r;
  logic [CW-1:0] span_r, a1_r, a2_r;
  logic [ERR_W-1:0] ea_r, eb_r;

  // Weight tracking: dist * 100 = q * span + r, with 100 = k * span + m.
  logic [WEIGHT_W-1:0] q_r, k_r;
  logic [CW-1:0]       r_r, m_r;

  // Divider registers.
  logic [CW-1:0]        div_rem_r;
  logic [WEIGHT_W-1:0]  div_q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Output register.
  logic                out_valid_r;
  logic [CW-1:0]       out_x_r, out_y_r, out_z_r;
  logic                out_inside_r, out_last_r;
  logic [WEIGHT_W-1:0] out_weight_r;

  logic in_take, out_load, fin;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_WALK) && (!out_valid_r || !out_stall);
  assign fin       = (pm_r == end_m_r);

  // ---------------------------------------------------------------------
  // Setup: deltas, dominant axis choice and initial error terms.
  // ---------------------------------------------------------------------
  logic [CW-1:0] dx, dy, dz;
  logic          nx, ny, nz;
  axis_t         su_maj;
  logic [CW-1:0] su_span, su_a1, su_a2, su_pm, su_p1, su_p2, su_end;
  logic          su_negm, su_neg1, su_neg2;

  always_comb begin
    nx = (e_x_r < s_x_r);
    ny = (e_y_r < s_y_r);
    nz = (e_z_r < s_z_r);
    dx = nx ? (s_x_r - e_x_r) : (e_x_r - s_x_r);
    dy = ny ? (s_y_r - e_y_r) : (e_y_r - s_y_r);
    dz = nz ? (s_z_r - e_z_r) : (e_z_r - s_z_r);
    if (dx >= dy && dx >= dz) begin
      su_maj = AXIS_X;
    end else if (dy >= dz) begin
      su_maj = AXIS_Y;
    end else begin
      su_maj = AXIS_Z;
    end
    case (su_maj)
      AXIS_Y: begin
        su_span = dy; su_a1 = dx; su_a2 = dz;
        su_pm = s_y_r; su_p1 = s_x_r; su_p2 = s_z_r; su_end = e_y_r;
        su_negm = ny; su_neg1 = nx; su_neg2 = nz;
      end
      AXIS_Z: begin
        su_span = dz; su_a1 = dx; su_a2 = dy;
        su_pm = s_z_r; su_p1 = s_x_r; su_p2 = s_y_r; su_end = e_z_r;
        su_negm = nz; su_neg1 = nx; su_neg2 = ny;
      end
      default: begin
        su_span = dx; su_a1 = dy; su_a2 = dz;
        su_pm = s_x_r; su_p1 = s_y_r; su_p2 = s_z_r; su_end = e_x_r;
        su_negm = nx; su_neg1 = ny; su_neg2 = nz;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Divider step: restoring, one quotient bit of 100 / span per cycle.
  // ---------------------------------------------------------------------
  logic [CW:0]         div_sh, div_sub;
  logic                div_bit;
  logic [CW-1:0]       div_rem_nxt;
  logic [WEIGHT_W-1:0] div_q_nxt;

  always_comb begin
    div_sh      = {div_rem_r, WEIGHT_FULL[div_cnt_r]};
    div_sub     = div_sh - {1'b0, span_r};
    div_bit     = (div_sh >= {1'b0, span_r});
    div_rem_nxt = div_bit ? div_sub[CW-1:0] : div_sh[CW-1:0];
    div_q_nxt   = {div_q_r[WEIGHT_W-2:0], div_bit};
  end

  // ---------------------------------------------------------------------
  // Walk step: next point, error terms and weight.
  // ---------------------------------------------------------------------
  logic [ERR_W-1:0]    a1x2, a2x2, emx2;
  logic                ge_a, ge_b;
  logic [CW-1:0]       pm_nxt, p1_nxt, p2_nxt;
  logic [ERR_W-1:0]    ea_nxt, eb_nxt;
  logic [CW:0]         r_diff;
  logic [CW-1:0]       r_nxt;
  logic [WEIGHT_W-1:0] q_nxt;
  logic [CW-1:0]       pt_x, pt_y, pt_z;
  logic                pt_inside;

  always_comb begin
    a1x2   = {2'b00, a1_r, 1'b0};
    a2x2   = {2'b00, a2_r, 1'b0};
    emx2   = {2'b00, span_r, 1'b0};
    ge_a   = !ea_r[ERR_W-1];
    ge_b   = !eb_r[ERR_W-1];
    // A minor axis with zero delta never moves even when its error is >= 0.
    p1_nxt = (ge_a && a1_r != '0) ? (p1_r + (neg1_r ? MONE : ONE)) : p1_r;
    p2_nxt = (ge_b && a2_r != '0) ? (p2_r + (neg2_r ? MONE : ONE)) : p2_r;
    pm_nxt = pm_r + (neg_m_r ? MONE : ONE);
    ea_nxt = ea_r + a1x2 - (ge_a ? emx2 : '0);
    eb_nxt = eb_r + a2x2 - (ge_b ? emx2 : '0);
    // Distance to end drops by one: subtract 100 = k*span + m, fix borrow.
    r_diff = {1'b0, r_r} - {1'b0, m_r};
    if (r_diff[CW]) begin
      r_nxt = r_diff[CW-1:0] + span_r;
      q_nxt = q_r - k_r - {{(WEIGHT_W-1){1'b0}}, 1'b1};
    end else begin
      r_nxt = r_diff[CW-1:0];
      q_nxt = q_r - k_r;
    end
    case (maj_r)
      AXIS_Y: begin pt_x = p1_r; pt_y = pm_r; pt_z = p2_r; end
      AXIS_Z: begin pt_x = p1_r; pt_y = p2_r; pt_z = pm_r; end
      default: begin pt_x = pm_r; pt_y = p1_r; pt_z = p2_r; end
    endcase
    pt_inside = ({1'b0, pt_x} < size_x_r) && ({1'b0, pt_y} < size_y_r) &&
                ({1'b0, pt_z} < size_z_r);
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        // Zero span means a single point: no divide needed.
        state_nxt = (su_span == '0) ? ST_WALK : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == '0) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (out_load && fin) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_x_r <= in_start_x;
      s_y_r <= in_start_y;
      s_z_r <= in_start_z;
      e_x_r <= in_end_x;
      e_y_r <= in_end_y;
      e_z_r <= in_end_z;
    end
    case (state_r)
      ST_SETUP: begin
        maj_r     <= su_maj;
        span_r    <= su_span;
        a1_r      <= su_a1;
        a2_r      <= su_a2;
        pm_r      <= su_pm;
        p1_r      <= su_p1;
        p2_r      <= su_p2;
        end_m_r   <= su_end;
        neg_m_r   <= su_negm;
        neg1_r    <= su_neg1;
        neg2_r    <= su_neg2;
        ea_r      <= {2'b00, su_a1, 1'b0} - {3'b000, su_span};
        eb_r      <= {2'b00, su_a2, 1'b0} - {3'b000, su_span};
        q_r       <= WEIGHT_FULL;
        r_r       <= '0;
        k_r       <= '0;
        m_r       <= '0;
        div_rem_r <= '0;
        div_q_r   <= '0;
        div_cnt_r <= DIV_CNT_TOP;
      end
      ST_DIV: begin
        div_rem_r <= div_rem_nxt;
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r - {{(DIV_CNT_W-1){1'b0}}, 1'b1};
        if (div_cnt_r == '0) begin
          k_r <= div_q_nxt;
          m_r <= div_rem_nxt;
        end
      end
      ST_WALK: begin
        if (out_load && !fin) begin
          pm_r <= pm_nxt;
          p1_r <= p1_nxt;
          p2_r <= p2_nxt;
          ea_r <= ea_nxt;
          eb_r <= eb_nxt;
          q_r  <= q_nxt;
          r_r  <= r_nxt;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a point when the slot is empty or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r      <= pt_x;
      out_y_r      <= pt_y;
      out_z_r      <= pt_z;
      out_inside_r <= pt_inside;
      out_weight_r <= q_r;
      out_last_r   <= fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_point_z    = out_z_r;
  assign out_inside_res = out_inside_r;
  assign out_weight_pct = out_weight_r;
  assign out_last       = out_last_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lr3d_pkg::*;

  localparam int unsigned COORD_BITS = 6;
  localparam int MAX_POINTS = 1 << COORD_BITS;
  localparam int COORD_MAX = MAX_POINTS - 1;
  // Index 3 has no register behind it: writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [COORD_BITS:0] EXTENT_RESET = 7'd64;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0] extent_t;

  // One predicted point beat, field for field as on the output port.
  typedef struct {
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                inside_res;
    logic [WEIGHT_W-1:0] weight_pct;
    logic                last;
  } voxel_t;

  // Every block input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  coord_t               in_start_x = '0;
  coord_t               in_start_y = '0;
  coord_t               in_start_z = '0;
  coord_t               in_end_x = '0;
  coord_t               in_end_y = '0;
  coord_t               in_end_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  coord_t               out_point_x;
  coord_t               out_point_y;
  coord_t               out_point_z;
  logic                 out_inside_res;
  logic [WEIGHT_W-1:0]  out_weight_pct;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  extent_t              cfg_data = '0;

  // Predictor copy of the volume registers and of the walker.
  extent_t vol_x = EXTENT_RESET;
  extent_t vol_y = EXTENT_RESET;
  extent_t vol_z = EXTENT_RESET;
  coord_t  walk_x = '0;
  coord_t  walk_y = '0;
  coord_t  walk_z = '0;
  int      walk_err_a = 0;
  int      walk_err_b = 0;
  axis_t   walk_axis = AXIS_X;

  // Points predicted and not yet seen on the output, oldest first.
  voxel_t  voxel_q[$];

  int fail_cnt = 0;
  int lines_sent = 0;
  int points_seen = 0;
  int cfg_writes = 0;

  // Idling knobs, changed per phase by the stimulus.
  bit stall_en = 1'b0;
  bit gap_en = 1'b0;
  int stall_odds = 4;
  int gap_odds = 4;
  int stall_cnt = 0;

  always #2 clk = ~clk;

  line_rasterizer_3d_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_start_z    (in_start_z),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_end_z      (in_end_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_inside_res(out_inside_res),
    .out_weight_pct(out_weight_pct),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int abs_delta(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int step_dir(int from_v, int to_v);
    return (to_v > from_v) ? 1 : ((to_v < from_v) ? -1 : 0);
  endfunction

  function automatic coord_t clamp_coord(int v);
    return (v < 0) ? coord_t'(0) : ((v > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(v));
  endfunction

  // Walk one 3D line and queue every point it produces. Deltas are doubled
  // so the half-delta error seed stays exact; the dominant axis steps on
  // every point, a minor axis whenever its error term is not negative.
  function automatic void predict_line(coord_t sx, coord_t sy, coord_t sz,
                                       coord_t ex, coord_t ey, coord_t ez);
    int     s[3];
    int     e[3];
    int     p[3];
    int     d2[3];
    int     dir[3];
    int     i, maj, mi1, mi2, em, ea, eb, span, n;
    bit     done;
    voxel_t v;
    s = '{int'(sx), int'(sy), int'(sz)};
    e = '{int'(ex), int'(ey), int'(ez)};
    for (i = 0; i < 3; i++) begin
      p[i] = s[i];
      d2[i] = 2 * abs_delta(s[i], e[i]);
      dir[i] = step_dir(s[i], e[i]);
    end
    // Ties go to x, then y.
    if (d2[0] >= d2[1] && d2[0] >= d2[2]) walk_axis = AXIS_X;
    else if (d2[1] >= d2[2]) walk_axis = AXIS_Y;
    else walk_axis = AXIS_Z;
    case (walk_axis)
      AXIS_X: begin
        maj = 0; mi1 = 1; mi2 = 2;
      end
      AXIS_Y: begin
        maj = 1; mi1 = 0; mi2 = 2;
      end
      default: begin
        maj = 2; mi1 = 0; mi2 = 1;
      end
    endcase
    em = d2[maj];
    ea = d2[mi1] - em / 2;
    eb = d2[mi2] - em / 2;
    span = abs_delta(s[maj], e[maj]);
    n = 0;
    done = 1'b0;
    while (!done) begin
      v.x = coord_t'(p[0]);
      v.y = coord_t'(p[1]);
      v.z = coord_t'(p[2]);
      v.inside_res = (p[0] < int'(vol_x)) && (p[1] < int'(vol_y)) && (p[2] < int'(vol_z));
      // Equal endpoints have no span: full weight on the single point.
      if (span != 0)
        v.weight_pct = WEIGHT_W'(abs_delta(p[maj], e[maj]) * int'(WEIGHT_FULL) / span);
      else
        v.weight_pct = WEIGHT_FULL;
      v.last = (p[maj] == e[maj]);
      voxel_q.push_back(v);
      walk_x = v.x;
      walk_y = v.y;
      walk_z = v.z;
      walk_err_a = ea;
      walk_err_b = eb;
      n++;
      if (v.last || n >= MAX_POINTS) begin
        done = 1'b1;
      end else begin
        if (ea >= 0) begin
          p[mi1] += dir[mi1];
          ea -= em;
        end
        if (eb >= 0) begin
          p[mi2] += dir[mi2];
          eb -= em;
        end
        p[maj] += dir[maj];
        ea += d2[mi1];
        eb += d2[mi2];
      end
    end
  endfunction

  // Count and report every mismatch.
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Output stall: random bursts of random length while enabled.
  always @(posedge clk) begin
    if (!rst_n || !stall_en) begin
      stall_cnt <= 0;
      out_stall <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, stall_odds) == 0) begin
      stall_cnt <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted point beat against the oldest prediction.
  always @(posedge clk) begin
    voxel_t want;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (voxel_q.size() == 0) begin
        fail_cnt++;
        $error("point beat (%0d,%0d,%0d) with nothing expected",
               out_point_x, out_point_y, out_point_z);
      end else begin
        want = voxel_q.pop_front();
        check_field("point_x", 32'(want.x), 32'(out_point_x));
        check_field("point_y", 32'(want.y), 32'(out_point_y));
        check_field("point_z", 32'(want.z), 32'(out_point_z));
        check_field("inside_res", 32'(want.inside_res), 32'(out_inside_res));
        check_field("weight_pct", 32'(want.weight_pct), 32'(out_weight_pct));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Send one line beat and predict its points once it is taken. Keep
  // in_valid high on return unless a gap was drawn, so a following call
  // in the same step never lowers and raises it.
  task automatic send_line(coord_t sx, coord_t sy, coord_t sz,
                           coord_t ex, coord_t ey, coord_t ez);
    in_valid <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_start_z <= sz;
    in_end_x <= ex;
    in_end_y <= ey;
    in_end_z <= ez;
    do @(posedge clk); while (in_stall);
    predict_line(sx, sy, sz, ex, ey, ez);
    lines_sent++;
    if (gap_en && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Hold the input off until every predicted point has come out.
  task automatic drain_points();
    in_valid <= 1'b0;
    while (voxel_q.size() != 0) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, extent_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIZE_X: vol_x = val;
      CFG_SIZE_Y: vol_y = val;
      CFG_SIZE_Z: vol_z = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Program the volume; a non-negative spare value also pokes the unused
  // index, which must leave every extent alone.
  task automatic set_volume(extent_t sx, extent_t sy, extent_t sz, int spare);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    if (spare >= 0) write_reg(CFG_IDX_SPARE, extent_t'(spare));
    cfg_valid <= 1'b0;
  endtask

  function automatic extent_t pick_extent();
    case ($urandom_range(0, 7))
      0: return extent_t'(0);
      1: return extent_t'(1);
      2: return EXTENT_RESET;
      3: return extent_t'(127);
      4: return extent_t'($urandom_range(65, 127));
      default: return extent_t'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic coord_t pick_edge_coord();
    case ($urandom_range(0, 2))
      0: return coord_t'(0);
      1: return coord_t'(COORD_MAX);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Extremes, each dominant axis and each tie order, under reset volume.
  task automatic test_directed_lines();
    send_line(0, 0, 0, 63, 63, 63);
    send_line(63, 63, 63, 0, 0, 0);
    send_line(0, 0, 0, 0, 0, 0);
    send_line(63, 63, 63, 63, 63, 63);
    send_line(0, 0, 0, 63, 10, 5);
    send_line(5, 0, 60, 0, 63, 40);
    send_line(10, 20, 0, 12, 25, 63);
    send_line(0, 0, 0, 20, 20, 3);
    send_line(30, 0, 0, 31, 40, 40);
    send_line(0, 5, 0, 30, 5, 30);
    send_line(63, 0, 63, 62, 1, 62);
    send_line(42, 21, 42, 21, 42, 21);
    drain_points();
  endtask

  // Zero extent, oversize extent, unit extent, and a dropped spare write.
  task automatic test_size_registers();
    set_volume(0, 127, 1, -1);
    send_line(0, 0, 0, 5, 63, 1);
    send_line(63, 10, 0, 60, 12, 4);
    drain_points();
    set_volume(1, 64, 127, 0);
    send_line(0, 62, 0, 3, 63, 63);
    send_line(2, 0, 63, 0, 5, 58);
    drain_points();
  endtask

  // Phases of random lines, each under a fresh volume and idling mix.
  task automatic test_random_lines(int phases, int per_phase);
    coord_t s[3];
    coord_t e[3];
    int     ph, k, i, kind, d;
    for (ph = 0; ph < phases; ph++) begin
      drain_points();
      set_volume(pick_extent(), pick_extent(), pick_extent(),
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 127)) : -1);
      stall_en = ($urandom_range(0, 3) != 0);
      gap_en = ($urandom_range(0, 3) != 0);
      stall_odds = $urandom_range(2, 12);
      gap_odds = $urandom_range(1, 8);
      for (k = 0; k < per_phase; k++) begin
        kind = $urandom_range(0, 9);
        d = $urandom_range(0, 20);
        for (i = 0; i < 3; i++) begin
          s[i] = coord_t'($urandom);
          case (kind)
            0, 1, 2, 3: e[i] = coord_t'($urandom);
            4, 5, 6: e[i] = clamp_coord(int'(s[i]) + $urandom_range(0, 14) - 7);
            7: begin
              s[i] = pick_edge_coord();
              e[i] = pick_edge_coord();
            end
            8: e[i] = s[i];
            default: begin
              // Equal deltas on random axes to exercise the tie order.
              s[i] = coord_t'($urandom_range(20, 43));
              e[i] = ($urandom_range(0, 1) != 0) ? s[i] + coord_t'(d) : s[i] - coord_t'(d);
              if ($urandom_range(0, 3) == 0) e[i] = clamp_coord(int'(s[i]) + $urandom_range(0, 6) - 3);
            end
          endcase
        end
        send_line(s[0], s[1], s[2], e[0], e[1], e[2]);
      end
    end
  endtask

  // Closing stretch: back-to-back lines, no gaps and no stalls.
  task automatic test_back_to_back(int count);
    int k;
    drain_points();
    set_volume(pick_extent(), pick_extent(), pick_extent(), -1);
    stall_en = 1'b0;
    gap_en = 1'b0;
    for (k = 0; k < count; k++)
      send_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_size_registers();
    test_random_lines(7, 40);
    test_back_to_back(40);

    // Wait out the remaining points, then let the pipeline settle.
    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && voxel_q.size() != 0; k++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (voxel_q.size() != 0) begin
      fail_cnt++;
      $error("%0d expected points never arrived", voxel_q.size());
    end

    $display("Walked %0d lines, %0d point beats checked, %0d register writes.",
             lines_sent, points_seen, cfg_writes);
    $display("Covered all dominant axes and ties, equal endpoints and empty or oversize volumes.");
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(4_000_000);
    $display("timeout: %0d points still expected", voxel_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lr3d_pkg.sv
design/line_rasterizer_3d_unit.sv
sim/tb.sv
